// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/lcr_pkg.sv =====
package lcr_pkg;

  localparam int READING_W  = 24;
  localparam int VOLUME_W   = 16;
  localparam int GAIN_W     = 2;
  localparam int SCOUNT_W   = 8;
  localparam int TIMEOUT_W  = 24;
  localparam int THRESH_W   = 24;
  localparam int UPM_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_SELECT         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIFTED_THRESHOLD    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONTAINER_THRESHOLD = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNITS_PER_ML        = 3'd5;

  localparam logic [GAIN_W-1:0]    GAIN_RESET      = 2'd0;
  localparam logic [GAIN_W-1:0]    GAIN_A64        = 2'd2;
  localparam logic [GAIN_W-1:0]    GAIN_UNUSED     = 2'd3;
  localparam logic [SCOUNT_W-1:0]  SCOUNT_RESET    = 8'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 24'd125000;
  localparam logic [THRESH_W-1:0]  LIFTED_RESET    = 24'd25000;
  localparam logic [THRESH_W-1:0]  CONTAINER_RESET = 24'd42000;
  localparam logic [UPM_W-1:0]     UPM_RESET       = 16'd150;

  localparam logic [VOLUME_W-1:0]  VOLUME_MAX      = 16'hFFFF;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef struct packed {
    logic dout_level;
    logic start_req;
  } item_t;

  typedef struct packed {
    logic                        sck_level;
    logic                        done_res;
    logic                        status;
    logic signed [READING_W-1:0] reading;
    logic [VOLUME_W-1:0]         volume;
    logic                        lifted;
    logic                        no_container;
  } result_t;

  typedef struct packed {
    logic sck_level;
    logic timeout;
    logic last_tick;
  } tick_res_t;

  typedef struct packed {
    logic signed [READING_W-1:0] reading;
    logic [VOLUME_W-1:0]         volume;
    logic                        lifted;
    logic                        no_container;
  } post_res_t;

endpackage

// ===== design/lcr_div.sv =====
`include "assert_macros.svh"

module lcr_div #(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW);

  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   rem;
  logic [NW-1:0]   quo;
  logic [DW-1:0]   dvs;
  logic [DW:0]     shifted;
  logic [DW+1:0]   trial;
  logic            fits;
  logic            last;

  assign shifted  = {rem, quo[NW-1]};
  assign trial    = {1'b0, shifted} - {2'b00, dvs};
  assign fits     = !trial[DW+1];
  assign last     = (cnt == CNTW'(NW - 1));
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NW-2:0], fits};
        rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPLIES(a_start_idle, clk, rst, start, !busy)
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_run_continues, clk, rst, busy && !last && !start, busy)

endmodule

// ===== design/lcr_tick.sv =====
module lcr_tick #(
  parameter int DATA_BITS         = 24,
  parameter int SAMPLE_COUNT_BITS = 8,
  parameter int TIMER_BITS        = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        accept,
  input  lcr_pkg::item_t                              item,
  input  logic [lcr_pkg::GAIN_W-1:0]                  gain,
  input  logic [SAMPLE_COUNT_BITS-1:0]                n_eff,
  input  logic [TIMER_BITS-1:0]                       limit,
  output lcr_pkg::tick_res_t                          res,
  output logic                                        launch,
  output logic signed [DATA_BITS+SAMPLE_COUNT_BITS-1:0] sum
);

  import lcr_pkg::*;

  localparam int SW = DATA_BITS + SAMPLE_COUNT_BITS;
  localparam int PW = $clog2(DATA_BITS + 4);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t                        phase;
  logic [PW-1:0]                 pulse_count;
  logic [DATA_BITS-1:0]          shift_value;
  logic [TIMER_BITS-1:0]         wait_timer;
  logic [SAMPLE_COUNT_BITS-1:0]  samples_taken;

  logic [GAIN_W-1:0]             extra_m1;
  logic [PW-1:0]                 pulse_lim;
  logic [PW-1:0]                 pulse_inc;
  logic [TIMER_BITS-1:0]         timer_inc;
  logic [SAMPLE_COUNT_BITS-1:0]  samples_inc;
  logic                          bits_done;
  logic                          timed_out;
  logic                          last_sample;
  logic signed [SW-1:0]          sum_add;

  always_comb begin
    extra_m1    = (gain == GAIN_UNUSED) ? GAIN_A64 : gain;
    pulse_lim   = PW'(DATA_BITS) + PW'(extra_m1) + PW'(1);
    pulse_inc   = pulse_count + 1'b1;
    bits_done   = (pulse_inc >= pulse_lim);
    timer_inc   = wait_timer + 1'b1;
    timed_out   = (timer_inc >= limit);
    samples_inc = samples_taken + 1'b1;
    last_sample = (samples_inc >= n_eff);
    sum_add     = sum + SW'($signed(shift_value));

    res.sck_level = (phase == PH_HIGH);
    res.timeout   = (phase == PH_WAIT) && item.dout_level && timed_out;
    res.last_tick = (phase == PH_LOW) && bits_done && last_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      pulse_count   <= '0;
      shift_value   <= '0;
      wait_timer    <= '0;
      samples_taken <= '0;
      sum           <= '0;
      launch        <= 1'b0;
    end else begin
      launch <= accept && res.last_tick;
      if (accept) begin
        case (phase)
          PH_IDLE: begin
            if (item.start_req) begin
              sum           <= '0;
              samples_taken <= '0;
              pulse_count   <= '0;
              shift_value   <= '0;
              wait_timer    <= '0;
              phase         <= (limit == '0) ? PH_HIGH : PH_WAIT;
            end
          end
          PH_WAIT: begin
            if (!item.dout_level) begin
              phase <= PH_HIGH;
            end else begin
              wait_timer <= timer_inc;
              if (timed_out) begin
                phase <= PH_IDLE;
              end
            end
          end
          PH_HIGH: begin
            if (pulse_count < PW'(DATA_BITS)) begin
              shift_value <= {shift_value[DATA_BITS-2:0], item.dout_level};
            end
            phase <= PH_LOW;
          end
          PH_LOW: begin
            pulse_count <= pulse_inc;
            if (bits_done) begin
              sum           <= sum_add;
              samples_taken <= samples_inc;
              if (last_sample) begin
                phase <= PH_IDLE;
              end else begin
                pulse_count <= '0;
                shift_value <= '0;
                wait_timer  <= '0;
                phase       <= (limit == '0) ? PH_HIGH : PH_WAIT;
              end
            end else begin
              phase <= PH_HIGH;
            end
          end
          default: phase <= PH_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== design/lcr_post.sv =====
module lcr_post #(
  parameter int DATA_BITS         = 24,
  parameter int SAMPLE_COUNT_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          launch,
  input  logic signed [DATA_BITS+SAMPLE_COUNT_BITS-1:0] sum,
  input  logic [SAMPLE_COUNT_BITS-1:0]                  n_eff,
  input  logic signed [lcr_pkg::THRESH_W-1:0]           lifted_thr,
  input  logic signed [lcr_pkg::THRESH_W-1:0]           container_thr,
  input  logic [lcr_pkg::UPM_W-1:0]                     upm_eff,
  output logic                                          busy,
  output logic                                          done,
  output lcr_pkg::post_res_t                            res
);

  import lcr_pkg::*;

  localparam int SW = DATA_BITS + SAMPLE_COUNT_BITS;
  localparam int RW = (DATA_BITS > READING_W) ? DATA_BITS : READING_W;
  localparam int CW = RW + 1;
  localparam int WD = (SW > CW) ? SW : CW;
  localparam int DV = (SAMPLE_COUNT_BITS > UPM_W) ? SAMPLE_COUNT_BITS : UPM_W;

  typedef enum logic [1:0] {
    PS_IDLE,
    PS_AVG,
    PS_CMP,
    PS_VOL
  } post_state_t;

  post_state_t                 state;
  logic                        neg;
  logic signed [DATA_BITS-1:0] avg;

  logic [SW-1:0]               mag;
  logic signed [RW-1:0]        avg_r;
  logic signed [CW-1:0]        avg_c;
  logic signed [CW-1:0]        lt_c;
  logic signed [CW-1:0]        ct_c;
  logic signed [CW-1:0]        diff;
  logic                        not_lifted;
  logic                        has_cont;

  logic                        div_start;
  logic [WD-1:0]               div_dividend;
  logic [DV-1:0]               div_divisor;
  logic                        div_busy;
  logic                        div_done;
  logic [WD-1:0]               div_q;

  always_comb begin
    mag        = sum[SW-1] ? $unsigned(~sum + 1'b1) : $unsigned(sum);
    avg_r      = RW'(avg);
    avg_c      = CW'(avg);
    lt_c       = CW'(lifted_thr);
    ct_c       = CW'(container_thr);
    diff       = avg_c - ct_c;
    not_lifted = (avg_c > lt_c);
    has_cont   = (avg_c > ct_c);

    div_start    = ((state == PS_IDLE) && launch) ||
                   ((state == PS_CMP) && not_lifted && has_cont);
    div_dividend = (state == PS_IDLE) ? WD'(mag) : WD'($unsigned(diff));
    div_divisor  = (state == PS_IDLE) ? DV'(n_eff) : DV'(upm_eff);
  end

  assign busy = (state != PS_IDLE);

  lcr_div #(
    .NW(WD),
    .DW(DV)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        PS_IDLE: begin
          if (launch) begin
            neg   <= sum[SW-1];
            state <= PS_AVG;
          end
        end
        PS_AVG: begin
          if (div_done) begin
            avg   <= neg ? (~div_q[DATA_BITS-1:0] + 1'b1) : div_q[DATA_BITS-1:0];
            state <= PS_CMP;
          end
        end
        PS_CMP: begin
          res.reading      <= avg_r[READING_W-1:0];
          res.lifted       <= !not_lifted;
          res.no_container <= not_lifted && !has_cont;
          if (not_lifted && has_cont) begin
            state <= PS_VOL;
          end else begin
            res.volume <= '0;
            done       <= 1'b1;
            state      <= PS_IDLE;
          end
        end
        PS_VOL: begin
          if (div_done) begin
            res.volume <= (|div_q[WD-1:VOLUME_W]) ? VOLUME_MAX : div_q[VOLUME_W-1:0];
            done       <= 1'b1;
            state      <= PS_IDLE;
          end
        end
        default: state <= PS_IDLE;
      endcase
    end
  end

  logic unused_div_busy;
  assign unused_div_busy = div_busy;

endmodule

// ===== design/load_cell_adc_reader.sv =====
// Bit-banged reader for a 24-bit load cell converter. Each input transaction is one
// half-period tick of the converter's serial clock and yields exactly one result
// transaction carrying the clock level to drive for that tick. An ordinary tick's
// result is registered in the cycle after it is accepted, so a tick can be accepted
// every cycle while results are taken. The tick that completes the last sample of a
// measurement runs the average and the volume through one shared bit-serial
// restoring divider (one quotient bit per cycle) of WD bits, WD being the wider of
// DATA_BITS+SAMPLE_COUNT_BITS and max(DATA_BITS,24)+1. That tick registers a launch
// strobe, the average is divided, the reading is compared with the thresholds, and
// the volume is divided unless the reading shows the device lifted or no container;
// the block stalls its input until the result is loaded. Write configuration only
// between measurements.
`include "assert_macros.svh"

module load_cell_adc_reader #(
  parameter int DATA_BITS         = 24,
  parameter int SAMPLE_COUNT_BITS = 8,
  parameter int TIMER_BITS        = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  lcr_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output lcr_pkg::result_t                  result,
  input  logic                              cfg_we,
  input  logic [lcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lcr_pkg::*;

  localparam int SW  = DATA_BITS + SAMPLE_COUNT_BITS;
  localparam int SCW = (SAMPLE_COUNT_BITS > SCOUNT_W) ? SAMPLE_COUNT_BITS : SCOUNT_W;
  localparam int TW  = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

  logic [GAIN_W-1:0]           gain_select;
  logic [SCOUNT_W-1:0]         sample_count;
  logic [TIMEOUT_W-1:0]        timeout_ticks;
  logic signed [THRESH_W-1:0]  lifted_threshold;
  logic signed [THRESH_W-1:0]  container_threshold;
  logic [UPM_W-1:0]            units_per_ml;

  logic [SCW-1:0]               sc_wide;
  logic [SAMPLE_COUNT_BITS-1:0] n_raw;
  logic [SAMPLE_COUNT_BITS-1:0] n_eff;
  logic [TW-1:0]                tm_wide;
  logic [TIMER_BITS-1:0]        limit;
  logic [UPM_W-1:0]             upm_eff;

  logic                 item_accept;
  tick_res_t            tick_res;
  logic                 launch;
  logic signed [SW-1:0] sum;
  logic                 post_busy;
  logic                 post_done;
  post_res_t            post_res;

  always_comb begin
    sc_wide = SCW'(sample_count);
    n_raw   = sc_wide[SAMPLE_COUNT_BITS-1:0];
    n_eff   = (n_raw == '0) ? SAMPLE_COUNT_BITS'(1) : n_raw;
    tm_wide = TW'(timeout_ticks);
    limit   = tm_wide[TIMER_BITS-1:0];
    upm_eff = (units_per_ml == '0) ? UPM_W'(1) : units_per_ml;
  end

  assign item_stall  = launch || post_busy || post_done || (result_valid && result_stall);
  assign item_accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_select         <= GAIN_RESET;
      sample_count        <= SCOUNT_RESET;
      timeout_ticks       <= TIMEOUT_RESET;
      lifted_threshold    <= LIFTED_RESET;
      container_threshold <= CONTAINER_RESET;
      units_per_ml        <= UPM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_SELECT:         gain_select         <= cfg_data[GAIN_W-1:0];
        CFG_SAMPLE_COUNT:        sample_count        <= cfg_data[SCOUNT_W-1:0];
        CFG_TIMEOUT_TICKS:       timeout_ticks       <= cfg_data[TIMEOUT_W-1:0];
        CFG_LIFTED_THRESHOLD:    lifted_threshold    <= cfg_data[THRESH_W-1:0];
        CFG_CONTAINER_THRESHOLD: container_threshold <= cfg_data[THRESH_W-1:0];
        CFG_UNITS_PER_ML:        units_per_ml        <= cfg_data[UPM_W-1:0];
        default: ;
      endcase
    end
  end

  lcr_tick #(
    .DATA_BITS        (DATA_BITS),
    .SAMPLE_COUNT_BITS(SAMPLE_COUNT_BITS),
    .TIMER_BITS       (TIMER_BITS)
  ) u_tick (
    .clk    (clk),
    .rst    (rst),
    .accept (item_accept),
    .item   (item),
    .gain   (gain_select),
    .n_eff  (n_eff),
    .limit  (limit),
    .res    (tick_res),
    .launch (launch),
    .sum    (sum)
  );

  lcr_post #(
    .DATA_BITS        (DATA_BITS),
    .SAMPLE_COUNT_BITS(SAMPLE_COUNT_BITS)
  ) u_post (
    .clk           (clk),
    .rst           (rst),
    .launch        (launch),
    .sum           (sum),
    .n_eff         (n_eff),
    .lifted_thr    (lifted_threshold),
    .container_thr (container_threshold),
    .upm_eff       (upm_eff),
    .busy          (post_busy),
    .done          (post_done),
    .res           (post_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (item_accept && !tick_res.last_tick) begin
        result_valid        <= 1'b1;
        result.sck_level    <= tick_res.sck_level;
        result.done_res     <= tick_res.timeout;
        result.status       <= tick_res.timeout ? STATUS_TIMEOUT : STATUS_OK;
        result.reading      <= '0;
        result.volume       <= '0;
        result.lifted       <= 1'b0;
        result.no_container <= 1'b0;
      end
      if (post_done) begin
        result_valid        <= 1'b1;
        result.sck_level    <= 1'b0;
        result.done_res     <= 1'b1;
        result.status       <= STATUS_OK;
        result.reading      <= post_res.reading;
        result.volume       <= post_res.volume;
        result.lifted       <= post_res.lifted;
        result.no_container <= post_res.no_container;
      end
    end
  end

  logic timeout_clean;
  logic lifted_clean;

  assign timeout_clean = result.done_res && (result.reading == '0) && !result.sck_level;
  assign lifted_clean  = !result.no_container && (result.volume == '0);

  `ASSERT_IMPLIES(a_busy_stalls, clk, rst, post_busy || launch, item_stall)
  `ASSERT_IMPLIES(a_post_slot_free, clk, rst, post_done, !result_valid)
  `ASSERT_IMPLIES(a_timeout_fields, clk, rst, result_valid && result.status, timeout_clean)
  `ASSERT_IMPLIES(a_flags_excl, clk, rst, result_valid && result.lifted, lifted_clean)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lcr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 300;
  localparam int HOLD_OFF_BACKLOG = 20;
  localparam int SETTLE_CYCLES = 20;
  localparam int END_CYCLES = 100;
  localparam int RANDOM_TICKS = 500;
  localparam int RANDOM_MEASUREMENTS = 4;
  localparam int MAX_REPORTS = 10;

  localparam logic [GAIN_W-1:0] GAIN_B32 = 2'd1;

  typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_HIGH, ST_LOW} adc_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  load_cell_adc_reader uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies seen by the tick predictor.
  logic [GAIN_W-1:0] gain_sel = GAIN_RESET;
  logic [SCOUNT_W-1:0] avg_count = SCOUNT_RESET;
  logic [TIMEOUT_W-1:0] ready_timeout = TIMEOUT_RESET;
  logic signed [THRESH_W-1:0] lifted_thr = LIFTED_RESET;
  logic signed [THRESH_W-1:0] container_thr = CONTAINER_RESET;
  logic [UPM_W-1:0] per_ml = UPM_RESET;

  adc_state_t adc_state = ST_IDLE;
  int pulses = 0;
  logic [READING_W-1:0] shift_reg = '0;
  int wait_ticks = 0;
  int samples_done = 0;
  longint sample_sum = 0;
  logic sck_now = 1'b0;

  item_t ticks_to_send[$];
  result_t tick_results_due[$];
  logic [READING_W-1:0] planned_words[$];
  logic force_timeout = 1'b0;
  int wait_goal = 0;
  logic [READING_W-1:0] word_now = '0;

  int ticks_queued = 0;
  int measurements = 0;
  int timeouts = 0;
  int settings = 1;
  int results_seen = 0;
  int mismatches = 0;

  logic item_taken = 1'b0;
  int idle_cycles = 0;
  result_t due;

  int burst_left = 1;
  int gap_left = 0;

  int rx_cycle = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  function automatic void begin_conversion();
    pulses = 0;
    shift_reg = '0;
    wait_ticks = 0;
    adc_state = (ready_timeout == 0) ? ST_HIGH : ST_WAIT;
  endfunction

  function automatic result_t predict_tick(item_t it);
    result_t r;
    int extra;
    int n;
    logic signed [READING_W-1:0] conv;
    longint avg;
    longint lt;
    longint ct;
    longint upm;
    longint vol;
    r = '0;
    extra = ((gain_sel == GAIN_UNUSED) ? int'(GAIN_A64) : int'(gain_sel)) + 1;
    n = (avg_count == 0) ? 1 : int'(avg_count);
    case (adc_state)
      ST_IDLE: begin
        sck_now = 1'b0;
        if (it.start_req) begin
          sample_sum = 0;
          samples_done = 0;
          begin_conversion();
        end
      end
      ST_WAIT: begin
        sck_now = 1'b0;
        if (!it.dout_level) begin
          adc_state = ST_HIGH;
        end else begin
          wait_ticks++;
          if (wait_ticks >= ready_timeout) begin
            r.done_res = 1'b1;
            r.status = STATUS_TIMEOUT;
            adc_state = ST_IDLE;
          end
        end
      end
      ST_HIGH: begin
        sck_now = 1'b1;
        if (pulses < READING_W) shift_reg = {shift_reg[READING_W-2:0], it.dout_level};
        adc_state = ST_LOW;
      end
      default: begin
        sck_now = 1'b0;
        pulses++;
        if (pulses >= READING_W + extra) begin
          conv = shift_reg;
          sample_sum = sample_sum + conv;
          samples_done++;
          if (samples_done >= n) begin
            avg = sample_sum / n;
            lt = longint'(lifted_thr);
            ct = longint'(container_thr);
            upm = (per_ml == 0) ? longint'(1) : longint'(per_ml);
            vol = 0;
            if (avg > lt && avg > ct) vol = (avg - ct) / upm;
            r.done_res = 1'b1;
            r.status = STATUS_OK;
            r.reading = avg[READING_W-1:0];
            r.volume = (vol > 65535) ? VOLUME_MAX : vol[VOLUME_W-1:0];
            r.lifted = (avg <= lt);
            r.no_container = (avg > lt) && (avg <= ct);
            adc_state = ST_IDLE;
          end else begin
            begin_conversion();
          end
        end else begin
          adc_state = ST_HIGH;
        end
      end
    endcase
    r.sck_level = sck_now;
    return r;
  endfunction

  function automatic void queue_tick(logic d, logic s);
    item_t it;
    result_t r;
    it.dout_level = d;
    it.start_req = s;
    r = predict_tick(it);
    ticks_to_send.push_back(it);
    tick_results_due.push_back(r);
    ticks_queued++;
    if (r.done_res) begin
      measurements++;
      if (r.status == STATUS_TIMEOUT) timeouts++;
    end
  endfunction

  function automatic void queue_idle_ticks(int count);
    repeat (count) queue_tick(1'($urandom_range(0, 1)), 1'b0);
  endfunction

  function automatic logic [READING_W-1:0] pick_word();
    if (planned_words.size() > 0) return planned_words.pop_front();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return READING_W'(container_thr + $urandom_range(0, 4) - 2);
      3: return READING_W'(lifted_thr + $urandom_range(0, 4) - 2);
      4: return $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
      default: return READING_W'($urandom());
    endcase
  endfunction

  function automatic logic [THRESH_W-1:0] pick_threshold();
    case ($urandom_range(0, 3))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return THRESH_W'($urandom_range(0, 200000) - 100000);
      default: return THRESH_W'($urandom());
    endcase
  endfunction

  // One start request, then ticks shaped by the predicted state, with stray start bits, until the block is idle.
  function automatic void queue_measurement();
    logic d;
    logic s;
    queue_tick(1'($urandom_range(0, 1)), 1'b1);
    while (adc_state != ST_IDLE) begin
      d = 1'($urandom_range(0, 1));
      s = ($urandom_range(0, 9) == 0);
      if (adc_state == ST_WAIT) begin
        if (wait_ticks == 0) begin
          if (force_timeout || (ready_timeout <= 60 && $urandom_range(0, 5) == 0))
            wait_goal = int'(ready_timeout);
          else
            wait_goal = $urandom_range(0, (ready_timeout > 5) ? 4 : ready_timeout - 1);
          force_timeout = 1'b0;
        end
        d = (wait_ticks < wait_goal);
      end else if (adc_state == ST_HIGH && pulses < READING_W) begin
        if (pulses == 0) word_now = pick_word();
        d = word_now[READING_W-1-pulses];
      end
      queue_tick(d, s);
    end
  endfunction

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_settings(logic [GAIN_W-1:0] g, logic [SCOUNT_W-1:0] n,
                                logic [TIMEOUT_W-1:0] to, logic [THRESH_W-1:0] lt,
                                logic [THRESH_W-1:0] ct, logic [UPM_W-1:0] upm);
    while (ticks_to_send.size() > 0 || tick_results_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_GAIN_SELECT, CFG_DATA_W'(g));
    write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(n));
    write_reg(CFG_TIMEOUT_TICKS, to);
    write_reg(CFG_LIFTED_THRESHOLD, lt);
    write_reg(CFG_CONTAINER_THRESHOLD, ct);
    write_reg(CFG_UNITS_PER_ML, CFG_DATA_W'(upm));
    @(negedge clk);
    cfg_we <= 1'b0;
    gain_sel = g;
    avg_count = n;
    ready_timeout = to;
    lifted_thr = lt;
    container_thr = ct;
    per_ml = upm;
    settings++;
  endtask

  initial begin
    int rnd_ticks;
    int rnd_meas;
    logic [GAIN_W-1:0] g;
    logic [SCOUNT_W-1:0] n;
    logic [TIMEOUT_W-1:0] to;
    logic [THRESH_W-1:0] lt;
    logic [THRESH_W-1:0] ct;
    logic [UPM_W-1:0] upm;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_idle_ticks(3);
    planned_words.push_back(24'h7FFFFF);
    queue_measurement();

    apply_settings(GAIN_UNUSED, 8'd0, 24'd0, 24'h800000, 24'h7FFFFF, 16'd0);
    planned_words.push_back(24'h800000);
    planned_words.push_back(24'h7FFFFF);
    queue_measurement();
    queue_measurement();

    apply_settings(GAIN_B32, 8'd2, 24'd2, 24'h800000, 24'hFFFFF0, 16'd1);
    force_timeout = 1'b1;
    queue_measurement();
    planned_words.push_back(24'h7FFFFF);
    planned_words.push_back(24'h7FFFFF);
    queue_measurement();

    apply_settings(GAIN_A64, 8'd3, 24'hFFFFFF, 24'h7FFFFF, 24'd0, 16'hFFFF);
    queue_measurement();

    rnd_ticks = ticks_queued;
    rnd_meas = measurements;
    while (ticks_queued - rnd_ticks < RANDOM_TICKS ||
           measurements - rnd_meas < RANDOM_MEASUREMENTS) begin
      g = GAIN_W'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: n = 8'd0;
        1: n = SCOUNT_W'($urandom_range(4, 8));
        default: n = SCOUNT_W'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 5))
        0: to = '0;
        1: to = 24'd1;
        2: to = TIMEOUT_W'($urandom_range(2, 12));
        3: to = '1;
        4: to = TIMEOUT_W'($urandom());
        default: to = TIMEOUT_W'($urandom_range(13, 60));
      endcase
      lt = pick_threshold();
      ct = pick_threshold();
      case ($urandom_range(0, 3))
        0: upm = 16'd1;
        1: upm = '1;
        2: upm = UPM_W'($urandom_range(1, 300));
        default: upm = UPM_W'($urandom());
      endcase
      apply_settings(g, n, to, lt, ct, upm);
      repeat ($urandom_range(1, 2)) begin
        queue_idle_ticks($urandom_range(0, 3));
        queue_measurement();
      end
    end

    while (ticks_to_send.size() > 0 || tick_results_due.size() > 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("Sent %0d ticks under %0d register settings: %0d measurements, %0d timeouts.",
             ticks_queued, settings, measurements - timeouts, timeouts);
    $display("Checked %0d result transactions, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && tick_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_taken) begin
        void'(ticks_to_send.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!item_valid || item_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (ticks_to_send.size() > 0) begin
          item_valid <= 1'b1;
          item <= ticks_to_send[0];
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (!hold_done && results_seen >= HOLD_OFF_AFTER &&
          ticks_to_send.size() > HOLD_OFF_BACKLOG) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case ((rx_cycle / 1500) % 4)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ((rx_cycle % 7) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      item_taken <= item_valid && !item_stall;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (tick_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result transaction %0d arrived with nothing expected", results_seen);
        end else begin
          due = tick_results_due.pop_front();
          if (result !== due) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("result %0d expected: sck=%b done=%b st=%b rd=%0d vol=%0d lf=%b nc=%b",
                       results_seen, due.sck_level, due.done_res, due.status, due.reading,
                       due.volume, due.lifted, due.no_container);
              $display("result %0d actual:   sck=%b done=%b st=%b rd=%0d vol=%0d lf=%b nc=%b",
                       results_seen, result.sck_level, result.done_res, result.status,
                       result.reading, result.volume, result.lifted, result.no_container);
            end
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 idle_cycles, tick_results_due.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+design
design/lcr_pkg.sv
design/lcr_div.sv
design/lcr_tick.sv
design/lcr_post.sv
design/load_cell_adc_reader.sv
tb/tb_top.sv
